/* hw/rtl/mtep_pkg.sv */
// ============================================================================
// mtep_pkg: shared types and constants of the MIDI track event parser
// Holds the parse phases, event kinds and the record passed front to back.
// ============================================================================
package mtep_pkg;

    localparam int DELTA_BITS = 28;
    localparam int TPQ_W      = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int PROD_W     = DELTA_BITS + 24;
    localparam int DIV_W      = TPQ_W + 10;
    localparam int CNT_W      = 6;
    localparam logic [9:0] MS_SCALE = 10'd1000;
    localparam logic [23:0] TEMPO_RESET = 24'd500000;
    localparam logic [7:0]  SIG_NUM_RESET = 8'd4;
    localparam logic [7:0]  SIG_DEN_RESET = 8'd2;
    localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd96;
    localparam logic [7:0] META_SET_TEMPO = 8'h51;
    localparam logic [7:0] META_TSIG      = 8'h58;
    localparam logic [7:0] META_EOT       = 8'h2F;
    localparam logic [7:0] BYTE_META      = 8'hFF;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
        PH_META_LEN, PH_META_BODY, PH_SYX_LEN, PH_SYX_BODY
    } phase_t;

    typedef enum logic [2:0] {
        EV_CHANNEL  = 3'd0,
        EV_TEMPO    = 3'd1,
        EV_TSIG     = 3'd2,
        EV_EOT      = 3'd3,
        EV_META     = 3'd4,
        EV_SYSEX    = 3'd5,
        EV_UNKNOWN  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        DV_IDLE, DV_MUL, DV_DIV, DV_DONE
    } div_state_t;

    // One parsed event as handed to the timing back end
    typedef struct packed {
        logic [2:0]            kind;
        logic [DELTA_BITS-1:0] ticks;
        logic [7:0]            status;
        logic [7:0]            data1;
        logic [7:0]            data2;
        logic [23:0]           tempo;
        logic [7:0]            sig_num;
        logic [7:0]            sig_den;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

endpackage

/* hw/rtl/mtep_ram.sv */
// ============================================================================
// mtep_ram: generic one-write one-read RAM
// Synchronous write, registered read data.
// ============================================================================
module mtep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* hw/rtl/mtep_parser.sv */
// ============================================================================
// mtep_parser: byte-level track event parser (front end)
// Walks delta times, status, data and meta/sysex lengths one byte a cycle while take is high.
// ============================================================================
module mtep_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        byte_in,
    input  logic              track_start,
    output logic              ev_valid,
    output mtep_pkg::event_t  ev
);

    localparam int DB = mtep_pkg::DELTA_BITS;

    mtep_pkg::phase_t  phase_reg, phase_next;
    logic [DB-1:0]     vlq_reg, vlq_next;
    logic [DB-1:0]     delta_reg, delta_next;
    logic [7:0]        hstat_reg, hstat_next;
    logic [7:0]        hdata_reg, hdata_next;
    logic [7:0]        mkind_reg, mkind_next;
    logic [DB-1:0]     left_reg, left_next;
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [23:0]       tbuild_reg, tbuild_next;
    logic [23:0]       tempo_reg, tempo_next;
    logic [7:0]        snum_reg, snum_next;
    logic [7:0]        sden_reg, sden_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mtep_pkg::PH_DELTA;
            vlq_reg    <= '0;
            delta_reg  <= '0;
            hstat_reg  <= '0;
            hdata_reg  <= '0;
            mkind_reg  <= '0;
            left_reg   <= '0;
            pcnt_reg   <= '0;
            tbuild_reg <= '0;
            tempo_reg  <= mtep_pkg::TEMPO_RESET;
            snum_reg   <= mtep_pkg::SIG_NUM_RESET;
            sden_reg   <= mtep_pkg::SIG_DEN_RESET;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            vlq_reg    <= vlq_next;
            delta_reg  <= delta_next;
            hstat_reg  <= hstat_next;
            hdata_reg  <= hdata_next;
            mkind_reg  <= mkind_next;
            left_reg   <= left_next;
            pcnt_reg   <= pcnt_next;
            tbuild_reg <= tbuild_next;
            tempo_reg  <= tempo_next;
            snum_reg   <= snum_next;
            sden_reg   <= sden_next;
        end
    end

    // Next state and event output
    always_comb
    begin
        mtep_pkg::phase_t ph;
        logic [DB-1:0]    vlq;
        logic [DB-1:0]    vshift;
        logic [2:0]       kind;
        logic             fin_meta;
        logic [DB-1:0]    left_dec;

        ph          = phase_reg;
        vlq         = vlq_reg;
        phase_next  = phase_reg;
        delta_next  = delta_reg;
        hstat_next  = hstat_reg;
        hdata_next  = hdata_reg;
        mkind_next  = mkind_reg;
        left_next   = left_reg;
        pcnt_next   = pcnt_reg;
        tbuild_next = tbuild_reg;
        tempo_next  = tempo_reg;
        snum_next   = snum_reg;
        sden_next   = sden_reg;
        ev_valid    = 1'b0;
        kind        = mtep_pkg::EV_UNKNOWN;
        fin_meta    = 1'b0;
        ev.status   = 8'd0;
        ev.data1    = 8'd0;
        ev.data2    = 8'd0;

        // Restart the parse on track start
        if (track_start)
        begin
            ph          = mtep_pkg::PH_DELTA;
            vlq         = '0;
            delta_next  = '0;
            hstat_next  = '0;
            hdata_next  = '0;
            mkind_next  = '0;
            left_next   = '0;
            pcnt_next   = '0;
            tbuild_next = '0;
            phase_next  = mtep_pkg::PH_DELTA;
        end

        vshift   = {vlq[DB-8:0], byte_in[6:0]};
        left_dec = left_next - 1'b1;
        vlq_next = vlq;

        unique case (ph)
            mtep_pkg::PH_DELTA:
            begin
                vlq_next = vshift;
                if (!byte_in[7])
                begin
                    delta_next = vshift;
                    vlq_next   = '0;
                    phase_next = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS:
            begin
                if (!byte_in[7])
                begin
                    ev_valid = 1'b1;
                    kind     = mtep_pkg::EV_UNKNOWN;
                    // Byte opens the next delta time
                    vlq_next   = {{(DB-7){1'b0}}, byte_in[6:0]};
                    phase_next = mtep_pkg::PH_DELTA;
                    if (!byte_in[7])
                    begin
                        delta_next = {{(DB-7){1'b0}}, byte_in[6:0]};
                        vlq_next   = '0;
                        phase_next = mtep_pkg::PH_STATUS;
                    end
                end
                else if (byte_in == mtep_pkg::BYTE_META)
                begin
                    phase_next = mtep_pkg::PH_META_TYPE;
                end
                else if (byte_in[7:4] == 4'hF)
                begin
                    vlq_next   = '0;
                    phase_next = mtep_pkg::PH_SYX_LEN;
                end
                else
                begin
                    hstat_next = byte_in;
                    phase_next = mtep_pkg::PH_DATA1;
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                if (hstat_next[7:4] == 4'hC || hstat_next[7:4] == 4'hD)
                begin
                    ev_valid   = 1'b1;
                    kind       = mtep_pkg::EV_CHANNEL;
                    ev.status  = hstat_next;
                    ev.data1   = byte_in;
                    phase_next = mtep_pkg::PH_DELTA;
                end
                else
                begin
                    hdata_next = byte_in;
                    phase_next = mtep_pkg::PH_DATA2;
                end
            end
            mtep_pkg::PH_DATA2:
            begin
                ev_valid   = 1'b1;
                kind       = mtep_pkg::EV_CHANNEL;
                ev.status  = hstat_next;
                ev.data1   = hdata_next;
                ev.data2   = byte_in;
                phase_next = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE:
            begin
                mkind_next  = byte_in;
                vlq_next    = '0;
                pcnt_next   = '0;
                tbuild_next = '0;
                phase_next  = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYX_LEN:
            begin
                vlq_next = vshift;
                if (!byte_in[7])
                begin
                    left_next = vshift;
                    vlq_next  = '0;
                    if (ph == mtep_pkg::PH_META_LEN)
                    begin
                        if (vshift == '0)
                            fin_meta = 1'b1;
                        else
                            phase_next = mtep_pkg::PH_META_BODY;
                    end
                    else if (vshift == '0)
                    begin
                        ev_valid   = 1'b1;
                        kind       = mtep_pkg::EV_SYSEX;
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        phase_next = mtep_pkg::PH_SYX_BODY;
                    end
                end
            end
            mtep_pkg::PH_META_BODY:
            begin
                if (pcnt_next != 2'd3)
                begin
                    tbuild_next = {tbuild_next[15:0], byte_in};
                    pcnt_next   = pcnt_next + 2'd1;
                end
                left_next = left_dec;
                if (left_dec == '0)
                    fin_meta = 1'b1;
            end
            mtep_pkg::PH_SYX_BODY:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    ev_valid   = 1'b1;
                    kind       = mtep_pkg::EV_SYSEX;
                    phase_next = mtep_pkg::PH_DELTA;
                end
            end
            default:
            begin
                phase_next = mtep_pkg::PH_DELTA;
            end
        endcase

        // Close a meta event and apply tempo or time signature
        if (fin_meta)
        begin
            ev_valid   = 1'b1;
            phase_next = mtep_pkg::PH_DELTA;
            if (mkind_next == mtep_pkg::META_SET_TEMPO)
            begin
                kind = mtep_pkg::EV_TEMPO;
                if (pcnt_next == 2'd3)
                    tempo_next = tbuild_next;
            end
            else if (mkind_next == mtep_pkg::META_TSIG)
            begin
                kind = mtep_pkg::EV_TSIG;
                if (pcnt_next == 2'd2)
                begin
                    snum_next = tbuild_next[15:8];
                    sden_next = tbuild_next[7:0];
                end
                else if (pcnt_next == 2'd3)
                begin
                    snum_next = tbuild_next[23:16];
                    sden_next = tbuild_next[15:8];
                end
            end
            else if (mkind_next == mtep_pkg::META_EOT)
                kind = mtep_pkg::EV_EOT;
            else
                kind = mtep_pkg::EV_META;
        end

        ev.kind    = kind;
        ev.ticks   = delta_next;
        ev.tempo   = tempo_next;
        ev.sig_num = snum_next;
        ev.sig_den = sden_next;
        // Unknown events report the delta held before this byte
        if (ph == mtep_pkg::PH_STATUS && !byte_in[7])
            ev.ticks = delta_reg;
        if (track_start && ph == mtep_pkg::PH_DELTA)
            ev.ticks = delta_next;
    end

endmodule

/* hw/rtl/mtep_fifo.sv */
// ============================================================================
// mtep_fifo: short event queue between parser and timing back end
// Stores parsed events in a small RAM; read data is prefetched one ahead.
// ============================================================================
module mtep_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  mtep_pkg::event_t  wdata,
    output logic              full,
    input  logic              rd,
    output logic              avail,
    output mtep_pkg::event_t  rdata
);

    localparam int AW = mtep_pkg::FIFO_AW;

    logic [AW:0]   wptr_reg, rptr_reg;
    logic [AW-1:0] raddr;
    logic          look_reg;
    logic [AW:0]   count;
    logic [mtep_pkg::EVENT_W-1:0] ram_q;

    assign count = wptr_reg - rptr_reg;
    assign full  = count == (AW+1)'(mtep_pkg::FIFO_DEPTH);
    // Data is valid once the RAM has registered a read at the settled read pointer
    assign avail = look_reg && (count != '0);
    assign raddr = rptr_reg[AW-1:0];
    assign rdata = mtep_pkg::event_t'(ram_q);

    mtep_ram #(
        .WIDTH (mtep_pkg::EVENT_W),
        .DEPTH (mtep_pkg::FIFO_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr && !full),
        .waddr (wptr_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Advance pointers; hold the lookahead flag off after a pop
    // or while the head entry is being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            look_reg <= 1'b0;
        end
        else
        begin
            if (wr && !full)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd && avail)
                rptr_reg <= rptr_reg + 1'b1;
            look_reg <= !(rd && avail) && (count != '0);
        end
    end

endmodule

/* hw/rtl/mtep_timer.sv */
// ============================================================================
// mtep_timer: delta ticks to milliseconds (back end)
// Multiplies ticks by tempo, divides by tpq*1000 one quotient bit a cycle,
// saturates and holds the finished result until it is popped.
// ============================================================================
module mtep_timer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mtep_pkg::TPQ_W-1:0]     tpq,
    input  logic                           q_avail,
    input  mtep_pkg::event_t               q_data,
    output logic                           q_rd,
    input  logic                           pop,
    output logic                           empty,
    output mtep_pkg::event_t               res,
    output logic [31:0]                    ms
);

    localparam int PW = mtep_pkg::PROD_W;
    localparam int DW = mtep_pkg::DIV_W;

    mtep_pkg::div_state_t st_reg, st_next;
    mtep_pkg::event_t     ev_reg;
    logic [PW-1:0]        quo_reg;
    logic [DW:0]          rem_reg;
    logic [DW-1:0]        dvs_reg;
    logic [mtep_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0]          ms_reg;
    logic [DW:0]          trial;
    logic [DW:0]          rsh;

    assign q_rd  = (st_reg == mtep_pkg::DV_IDLE) && q_avail;
    assign empty = st_reg != mtep_pkg::DV_DONE;
    assign res   = ev_reg;
    assign ms    = ms_reg;
    assign rsh   = {rem_reg[DW-1:0], quo_reg[PW-1]};
    assign trial = rsh - {1'b0, dvs_reg};

    // Sequencer
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            mtep_pkg::DV_IDLE: if (q_avail) st_next = mtep_pkg::DV_MUL;
            mtep_pkg::DV_MUL:  st_next = mtep_pkg::DV_DIV;
            mtep_pkg::DV_DIV:
                if (cnt_reg == mtep_pkg::CNT_W'(PW - 1)) st_next = mtep_pkg::DV_DONE;
            mtep_pkg::DV_DONE: if (pop) st_next = mtep_pkg::DV_IDLE;
            default:           st_next = mtep_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= mtep_pkg::DV_IDLE;
        else
            st_reg <= st_next;
    end

    // Datapath: product load, restoring division, saturation
    always_ff @(posedge clk)
    begin
        case (st_reg)
            mtep_pkg::DV_IDLE:
            begin
                ev_reg  <= q_data;
                dvs_reg <= DW'(tpq == '0 ? mtep_pkg::TPQ_W'(1) : tpq)
                           * DW'(mtep_pkg::MS_SCALE);
                cnt_reg <= '0;
            end
            mtep_pkg::DV_MUL:
            begin
                quo_reg <= PW'(ev_reg.ticks) * PW'(ev_reg.tempo);
                rem_reg <= '0;
            end
            mtep_pkg::DV_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!trial[DW])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rsh;
                    quo_reg <= {quo_reg[PW-2:0], 1'b0};
                end
                if (cnt_reg == mtep_pkg::CNT_W'(PW - 1))
                begin
                    if (!trial[DW])
                        ms_reg <= (|quo_reg[PW-2:31]) ? 32'hFFFF_FFFF
                                                      : {quo_reg[30:0], 1'b1};
                    else
                        ms_reg <= (|quo_reg[PW-2:31]) ? 32'hFFFF_FFFF
                                                      : {quo_reg[30:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/midi_track_event_parser_top.sv */
// ============================================================================
// midi_track_event_parser_top: MIDI track body event parser
// Parses one track byte per request and delivers one timed event per event.
// ============================================================================
//  channel   | handshake       | payload
//  ----------+-----------------+----------------------------------------------
//  input     | push / full     | byte_in, track_start
//  result    | empty / pop     | event_kind, delta_ms, status_out, data_first,
//            |                 | data_second, tempo_now, sig_num_now, sig_den_now
//  config    | cfg_we          | cfg_data (ticks per quarter)
//
//  The parser takes one byte a cycle; full rises only when the 4-entry event
//  queue fills. In the timer each event passes through one queue read, one
//  multiply, 52 restoring-divide steps (one per quotient bit) and the
//  presentation of the result.
//  rst_n clears all control state and restores tempo 500000 and 4/2 meter.
//  A result waiting on pop stalls the timer; the parser runs until full.
module midi_track_event_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    input  logic        track_start,
    input  logic        cfg_we,
    input  logic [14:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_kind,
    output logic [31:0] delta_ms,
    output logic [7:0]  status_out,
    output logic [7:0]  data_first,
    output logic [7:0]  data_second,
    output logic [23:0] tempo_now,
    output logic [7:0]  sig_num_now,
    output logic [7:0]  sig_den_now
);

    logic [mtep_pkg::TPQ_W-1:0] tpq_reg;
    logic              take;
    logic              ev_valid;
    mtep_pkg::event_t  ev;
    logic              q_full, q_avail, q_rd;
    mtep_pkg::event_t  q_data, res;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpq_reg <= mtep_pkg::TPQ_RESET;
        else if (cfg_we)
            tpq_reg <= cfg_data;
    end

    assign full = q_full;
    assign take = push && !q_full;

    mtep_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .byte_in     (byte_in),
        .track_start (track_start),
        .ev_valid    (ev_valid),
        .ev          (ev)
    );

    mtep_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (take && ev_valid),
        .wdata (ev),
        .full  (q_full),
        .rd    (q_rd),
        .avail (q_avail),
        .rdata (q_data)
    );

    mtep_timer u_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .tpq     (tpq_reg),
        .q_avail (q_avail),
        .q_data  (q_data),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .res     (res),
        .ms      (delta_ms)
    );

    assign event_kind  = res.kind;
    assign status_out  = res.status;
    assign data_first  = res.data1;
    assign data_second = res.data2;
    assign tempo_now   = res.tempo;
    assign sig_num_now = res.sig_num;
    assign sig_den_now = res.sig_den;

    // A result must stay put while it waits for pop
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(delta_ms) && $stable(event_kind)))
        else $error("result changed while waiting");

    // Never write into a full queue
    a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !take)
        else $error("write into full queue");

    // Kind codes beyond unknown never appear
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_kind != 3'd7))
        else $error("bad event kind");

endmodule

/* dv/midi_track_event_parser_top_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// midi_track_event_parser_top_tb: self-checking bench for the track parser
// Feeds hand-built and random MIDI track bytes through the push/full queue,
// predicts each parsed event and its millisecond delta, and checks every
// popped event field by field across several tick-division settings.
// ============================================================================
module midi_track_event_parser_top_tb;

    localparam int DRAIN_CYCLES = 150;
    localparam int DB = mtep_pkg::DELTA_BITS;

    typedef struct {
        mtep_pkg::kind_t kind;
        logic [31:0] ms;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [23:0] tempo;
        logic [7:0]  snum;
        logic [7:0]  sden;
    } midi_event_t;

    // directed row: byte, restart flag, optional hand-computed event
    typedef struct {
        logic [7:0]  b;
        logic        st;
        logic        typed;
        mtep_pkg::kind_t tkind;
        logic [31:0] tms;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  byte_in = 8'h00;
    logic        track_start = 1'b0;
    logic        cfg_we = 1'b0;
    logic [14:0] cfg_data = 15'd0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  event_kind;
    logic [31:0] delta_ms;
    logic [7:0]  status_out;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [23:0] tempo_now;
    logic [7:0]  sig_num_now;
    logic [7:0]  sig_den_now;

    midi_track_event_parser_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_in    (byte_in),
        .track_start(track_start),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop        (pop),
        .event_kind (event_kind),
        .delta_ms   (delta_ms),
        .status_out (status_out),
        .data_first (data_first),
        .data_second(data_second),
        .tempo_now  (tempo_now),
        .sig_num_now(sig_num_now),
        .sig_den_now(sig_den_now)
    );

    always #2 clk = ~clk;

    // parser shadow state
    mtep_pkg::phase_t      phase_q;
    logic [DB-1:0]         accum_q;
    logic [DB-1:0]         ticks_q;
    logic [DB-1:0]         left_q;
    logic [7:0]            stat_q;
    logic [7:0]            data_q;
    logic [7:0]            mtype_q;
    logic [1:0]            pcount_q;
    logic [23:0]           build_q;
    logic [23:0]           tempo_q = mtep_pkg::TEMPO_RESET;
    logic [7:0]            snum_q = mtep_pkg::SIG_NUM_RESET;
    logic [7:0]            sden_q = mtep_pkg::SIG_DEN_RESET;
    logic [mtep_pkg::TPQ_W-1:0] tpq_q = mtep_pkg::TPQ_RESET;

    midi_event_t pending_events[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          events_seen = 0;
    int          events_made = 0;
    int          tpq_settings = 1;
    bit          no_idle = 0;
    stim_row_t   rows[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void clear_parse();
        phase_q = mtep_pkg::PH_DELTA;
        accum_q = '0;
        ticks_q = '0;
        left_q = '0;
        stat_q = 8'h00;
        data_q = 8'h00;
        mtype_q = 8'h00;
        pcount_q = 2'd0;
        build_q = 24'd0;
    endfunction

    function automatic logic [31:0] ticks_to_ms();
        logic [63:0] tpq;
        logic [63:0] quo;
        tpq = (tpq_q == 0) ? 64'd1 : 64'(tpq_q);
        quo = (64'(ticks_q) * 64'(tempo_q)) / (tpq * 64'd1000);
        return (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    function automatic void queue_event(mtep_pkg::kind_t k, logic [7:0] s, logic [7:0] a,
                                        logic [7:0] b);
        midi_event_t e;
        e.kind = k;
        e.ms = ticks_to_ms();
        e.status = s;
        e.d1 = a;
        e.d2 = b;
        e.tempo = tempo_q;
        e.snum = snum_q;
        e.sden = sden_q;
        pending_events.push_back(e);
        events_made++;
    endfunction

    function automatic void take_delta_byte(logic [7:0] b);
        accum_q = {accum_q[DB-8:0], b[6:0]};
        if (!b[7])
        begin
            ticks_q = accum_q;
            accum_q = '0;
            phase_q = mtep_pkg::PH_STATUS;
        end
    endfunction

    function automatic void close_meta();
        mtep_pkg::kind_t k;
        k = mtep_pkg::EV_META;
        if (mtype_q == mtep_pkg::META_SET_TEMPO)
        begin
            k = mtep_pkg::EV_TEMPO;
            if (pcount_q == 2'd3)
                tempo_q = build_q;
        end
        else if (mtype_q == mtep_pkg::META_TSIG)
        begin
            k = mtep_pkg::EV_TSIG;
            if (pcount_q == 2'd2)
            begin
                snum_q = build_q[15:8];
                sden_q = build_q[7:0];
            end
            else if (pcount_q == 2'd3)
            begin
                snum_q = build_q[23:16];
                sden_q = build_q[15:8];
            end
        end
        else if (mtype_q == mtep_pkg::META_EOT)
            k = mtep_pkg::EV_EOT;
        phase_q = mtep_pkg::PH_DELTA;
        queue_event(k, 8'h00, 8'h00, 8'h00);
    endfunction

    // advance the parser shadow by one accepted byte
    function automatic void parse_byte(logic [7:0] b, logic st);
        if (st)
            clear_parse();
        case (phase_q)
            mtep_pkg::PH_DELTA: take_delta_byte(b);
            mtep_pkg::PH_STATUS:
            begin
                if (!b[7])
                begin
                    queue_event(mtep_pkg::EV_UNKNOWN, 8'h00, 8'h00, 8'h00);
                    phase_q = mtep_pkg::PH_DELTA;
                    accum_q = '0;
                    take_delta_byte(b);
                end
                else if (b == mtep_pkg::BYTE_META)
                    phase_q = mtep_pkg::PH_META_TYPE;
                else if (b[7:4] == 4'hF)
                begin
                    accum_q = '0;
                    phase_q = mtep_pkg::PH_SYX_LEN;
                end
                else
                begin
                    stat_q = b;
                    phase_q = mtep_pkg::PH_DATA1;
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                if (stat_q[7:4] == 4'hC || stat_q[7:4] == 4'hD)
                begin
                    queue_event(mtep_pkg::EV_CHANNEL, stat_q, b, 8'h00);
                    phase_q = mtep_pkg::PH_DELTA;
                end
                else
                begin
                    data_q = b;
                    phase_q = mtep_pkg::PH_DATA2;
                end
            end
            mtep_pkg::PH_DATA2:
            begin
                queue_event(mtep_pkg::EV_CHANNEL, stat_q, data_q, b);
                phase_q = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE:
            begin
                mtype_q = b;
                accum_q = '0;
                pcount_q = 2'd0;
                build_q = 24'd0;
                phase_q = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYX_LEN:
            begin
                accum_q = {accum_q[DB-8:0], b[6:0]};
                if (!b[7])
                begin
                    left_q = accum_q;
                    accum_q = '0;
                    if (phase_q == mtep_pkg::PH_META_LEN)
                    begin
                        if (left_q == 0)
                            close_meta();
                        else
                            phase_q = mtep_pkg::PH_META_BODY;
                    end
                    else if (left_q == 0)
                    begin
                        queue_event(mtep_pkg::EV_SYSEX, 8'h00, 8'h00, 8'h00);
                        phase_q = mtep_pkg::PH_DELTA;
                    end
                    else
                        phase_q = mtep_pkg::PH_SYX_BODY;
                end
            end
            mtep_pkg::PH_META_BODY:
            begin
                if (pcount_q != 2'd3)
                begin
                    build_q = {build_q[15:0], b};
                    pcount_q++;
                end
                left_q--;
                if (left_q == 0)
                    close_meta();
            end
            mtep_pkg::PH_SYX_BODY:
            begin
                left_q--;
                if (left_q == 0)
                begin
                    queue_event(mtep_pkg::EV_SYSEX, 8'h00, 8'h00, 8'h00);
                    phase_q = mtep_pkg::PH_DELTA;
                end
            end
            default:
            begin
                clear_parse();
                take_delta_byte(b);
            end
        endcase
    endfunction

    // compare every popped event with the oldest prediction
    always @(posedge clk)
    begin
        midi_event_t e;
        if (rst_n && pop && !empty)
        begin
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $display("MISMATCH unexpected event kind %0d at %0t", event_kind, $realtime);
                mismatches++;
            end
            else
            begin
                e = pending_events.pop_front();
                if (event_kind != e.kind)   report("event_kind", event_kind, e.kind);
                if (delta_ms != e.ms)       report("delta_ms", delta_ms, e.ms);
                if (status_out != e.status) report("status_out", status_out, e.status);
                if (data_first != e.d1)     report("data_first", data_first, e.d1);
                if (data_second != e.d2)    report("data_second", data_second, e.d2);
                if (tempo_now != e.tempo)   report("tempo_now", tempo_now, e.tempo);
                if (sig_num_now != e.snum)  report("sig_num_now", sig_num_now, e.snum);
                if (sig_den_now != e.sden)  report("sig_den_now", sig_den_now, e.sden);
            end
        end
    end

    // pop side: random stalls, one long hold-off to back the queue up
    initial
    begin
        int gap;
        int hold;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (events_seen >= 30 && hold == 0)
            begin
                hold = 1;
                gap = 900;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    // push one byte, holding the request until accepted
    task automatic send_byte(input logic [7:0] b, input logic st = 1'b0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        byte_in <= b;
        track_start <= st;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // accepted at this edge: advance the predictor
        parse_byte(b, st);
        bytes_sent++;
    endtask

    // send a value as a VLQ of at least nb bytes
    task automatic send_vlq(input logic [27:0] v, input int nb);
        int n;
        n = nb;
        while (n < 4 && (v >> (7 * n)) != 0)
            n++;
        for (int i = n - 1; i >= 0; i--)
            send_byte({(i != 0), 7'((v >> (7 * i)) & 28'h7F)});
    endtask

    task automatic send_random_event();
        int pick;
        int len;
        logic [27:0] dt;
        logic [7:0] s;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       dt = 28'($urandom());
            1, 2:    dt = 28'($urandom_range(0, 16383));
            default: dt = 28'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 24) == 0)
            send_byte(8'h80, 1'b1); // restart mid-VLQ
        send_vlq(dt, $urandom_range(0, 5) == 0 ? 2 : 1);
        if (pick < 40)
        begin
            s = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom())};
            send_byte(s);
            send_byte(8'($urandom()));
            if (s[7:4] != 4'hC && s[7:4] != 4'hD)
                send_byte(8'($urandom()));
        end
        else if (pick < 75)
        begin
            send_byte(mtep_pkg::BYTE_META);
            case ($urandom_range(0, 4))
                0, 1:    send_byte(mtep_pkg::META_SET_TEMPO);
                2:       send_byte(mtep_pkg::META_TSIG);
                3:       send_byte(mtep_pkg::META_EOT);
                default: send_byte(8'($urandom()));
            endcase
            len = $urandom_range(0, 5);
            send_vlq(28'(len), $urandom_range(0, 7) == 0 ? 2 : 1);
            for (int i = 0; i < len; i++)
                send_byte(i == 0 ? 8'($urandom_range(0, 15)) : 8'($urandom()));
        end
        else if (pick < 88)
        begin
            send_byte({4'hF, 4'($urandom_range(0, 14))});
            len = $urandom_range(0, 4);
            send_vlq(28'(len), 1);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom()));
        end
        else if (pick < 95)
            send_byte(8'($urandom_range(0, 127))); // data byte where status belongs
        else
            send_byte(8'($urandom()), 1'($urandom()));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_tpq(input logic [14:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tpq_q = v;
        tpq_settings++;
    endtask

    function automatic void add_row(logic [7:0] b, logic st = 1'b0, logic typed = 1'b0,
                                    mtep_pkg::kind_t k = mtep_pkg::EV_CHANNEL,
                                    logic [31:0] ms = 0);
        stim_row_t r;
        r.b = b;
        r.st = st;
        r.typed = typed;
        r.tkind = k;
        r.tms = ms;
        rows.push_back(r);
    endfunction

    initial
    begin
        int made;
        logic [14:0] tpq_list[4];
        clear_parse();
        tpq_list = '{15'd1, 15'd32767, 15'd480, 15'($urandom_range(2, 32766))};

        // 128 ticks at reset tempo and division, program change
        add_row(8'h81, 1'b1); add_row(8'h00); add_row(8'hC5);
        add_row(8'h10, 1'b0, 1'b1, mtep_pkg::EV_CHANNEL, 32'd666);
        // tempo to its maximum
        add_row(8'h00); add_row(8'hFF); add_row(8'h51); add_row(8'h03);
        add_row(8'hFF); add_row(8'hFF);
        add_row(8'hFF, 1'b0, 1'b1, mtep_pkg::EV_TEMPO, 32'd0);
        // two-byte time signature
        add_row(8'h00); add_row(8'hFF); add_row(8'h58); add_row(8'h02);
        add_row(8'h03); add_row(8'h03, 1'b0, 1'b1, mtep_pkg::EV_TSIG, 32'd0);
        // zero-length end of track and sysex
        add_row(8'h00); add_row(8'hFF); add_row(8'h2F);
        add_row(8'h00, 1'b0, 1'b1, mtep_pkg::EV_EOT, 32'd0);
        add_row(8'h00); add_row(8'hF0);
        add_row(8'h00, 1'b0, 1'b1, mtep_pkg::EV_SYSEX, 32'd0);
        // data byte where a status belongs, then it starts the next delta
        add_row(8'h05); add_row(8'h42, 1'b0, 1'b1, mtep_pkg::EV_UNKNOWN, 32'd873);
        add_row(8'hD0); add_row(8'h7F);
        // widest delta saturates the millisecond count
        add_row(8'hFF); add_row(8'hFF); add_row(8'hFF); add_row(8'h7F);
        add_row(8'h80); add_row(8'h00);
        add_row(8'h7F, 1'b0, 1'b1, mtep_pkg::EV_CHANNEL, 32'hFFFF_FFFF);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            made = events_made;
            send_byte(rows[i].b, rows[i].st);
            // hand-computed rows also pin the predictor
            if (rows[i].typed)
            begin
                if (events_made != made + 1)
                    report("directed event count", events_made - made, 1);
                else
                begin
                    if (pending_events[$].kind != rows[i].tkind)
                        report("directed kind", pending_events[$].kind, rows[i].tkind);
                    if (pending_events[$].ms != rows[i].tms)
                        report("directed delta_ms", pending_events[$].ms, rows[i].tms);
                end
            end
        end

        // random tracks over five tick divisions
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                set_tpq(tpq_list[ph-1]);
            made = bytes_sent;
            while (bytes_sent - made < 215)
            begin
                if ($urandom_range(0, 30) == 0)
                    no_idle = ~no_idle;
                send_random_event();
            end
        end
        no_idle = 0;
        drain();

        $display("covered %0d bytes and %0d events over %0d tick divisions",
                 bytes_sent, events_seen, tpq_settings);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d events outstanding", pending_events.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
